/* src/ccf_pkg.sv */
// Shared output width and the result record of the circumcircle block.
package ccf_pkg;

  localparam int OUT_BITS = 48;

  typedef struct packed {
    logic signed [OUT_BITS-1:0] center_x;
    logic signed [OUT_BITS-1:0] center_y;
    logic [OUT_BITS-1:0]        radius;
    logic                       collinear;
    logic                       saturated;
  } ccf_result_t;

endpackage

/* src/ccf_div_cell.sv */
// One restoring-division cell: settles one quotient bit of each centre lane.
module ccf_div_cell #(
  parameter int NUM_W = 8,
  parameter int DIV_W = 8,
  parameter int SB_W  = 1
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             en,
  input  logic             valid_in,
  input  logic [NUM_W-1:0] num_x_in,
  input  logic [DIV_W-1:0] rem_x_in,
  input  logic [NUM_W-1:0] num_y_in,
  input  logic [DIV_W-1:0] rem_y_in,
  input  logic [DIV_W-1:0] divisor_in,
  input  logic [SB_W-1:0]  side_in,
  output logic             valid_out,
  output logic [NUM_W-1:0] num_x_out,
  output logic [DIV_W-1:0] rem_x_out,
  output logic [NUM_W-1:0] num_y_out,
  output logic [DIV_W-1:0] rem_y_out,
  output logic [DIV_W-1:0] divisor_out,
  output logic [SB_W-1:0]  side_out
);

  logic [DIV_W:0] trial_x, trial_y, diff_x, diff_y;
  logic           ge_x, ge_y;

  // The numerator shifts out at the top while quotient bits fill in at the bottom.
  always_comb begin
    trial_x = {rem_x_in, num_x_in[NUM_W-1]};
    trial_y = {rem_y_in, num_y_in[NUM_W-1]};
    diff_x  = trial_x - {1'b0, divisor_in};
    diff_y  = trial_y - {1'b0, divisor_in};
    ge_x    = trial_x >= {1'b0, divisor_in};
    ge_y    = trial_y >= {1'b0, divisor_in};
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      valid_out <= 1'b0;
    end else if (en) begin
      valid_out <= valid_in;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      num_x_out   <= {num_x_in[NUM_W-2:0], ge_x};
      num_y_out   <= {num_y_in[NUM_W-2:0], ge_y};
      rem_x_out   <= ge_x ? diff_x[DIV_W-1:0] : trial_x[DIV_W-1:0];
      rem_y_out   <= ge_y ? diff_y[DIV_W-1:0] : trial_y[DIV_W-1:0];
      divisor_out <= divisor_in;
      side_out    <= side_in;
    end
  end

endmodule

/* src/ccf_sqrt_cell.sv */
// One digit-by-digit square-root cell: settles one root bit per cycle while en is high.
module ccf_sqrt_cell #(
  parameter int ROOT_W = 8,
  parameter int SB_W   = 1
) (
  input  logic                clk,
  input  logic                rst,
  input  logic                en,
  input  logic                valid_in,
  input  logic [2*ROOT_W-1:0] rad_in,
  input  logic [ROOT_W+1:0]   rem_in,
  input  logic [ROOT_W-1:0]   root_in,
  input  logic [SB_W-1:0]     side_in,
  output logic                valid_out,
  output logic [2*ROOT_W-1:0] rad_out,
  output logic [ROOT_W+1:0]   rem_out,
  output logic [ROOT_W-1:0]   root_out,
  output logic [SB_W-1:0]     side_out
);

  logic [ROOT_W+1:0] trial, test;
  logic              ge;

  // Before the last step the remainder stays below 2^ROOT_W, so its top bits drop.
  always_comb begin
    trial = {rem_in[ROOT_W-1:0], rad_in[2*ROOT_W-1 -: 2]};
    test  = {root_in, 2'b01};
    ge    = trial >= test;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      valid_out <= 1'b0;
    end else if (en) begin
      valid_out <= valid_in;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      rad_out  <= {rad_in[2*ROOT_W-3:0], 2'b00};
      rem_out  <= ge ? (trial - test) : trial;
      root_out <= {root_in[ROOT_W-2:0], ge};
      side_out <= side_in;
    end
  end

endmodule

/* src/circumcircle_from_three_points_top.sv */
// Circumcircle of three points: streaming pipeline with division and root cell chains.
//
// Input transaction: in_valid/in_ready carry the three points a, b and c as signed
// integers. Output transaction: out_valid/out_ready carry the centre (signed, FRAC_BITS
// fraction bits, toward zero, clipped), the radius (unsigned, rounded down, clipped),
// the collinear flag (all other fields zero) and the saturated flag.
// Throughput is one transaction per cycle while no stall holds the pipeline: every
// stage and every cell advances together. The chains hold DNW = 3*COORD_BITS + 3 +
// FRAC_BITS division cells (one quotient bit each) and RW root cells (one root bit
// each); at the default parameters that is 67 division and 50 root cells.
// A two-entry output queue sits after the root chain. in_ready depends on that queue
// and on the valid bit at the end of the root chain, never on out_ready: when the
// receiver stalls, the queue fills and the whole pipeline holds while the queue is full
// and a result waits at the chain end; it moves again the cycle after an entry drains,
// so nothing is lost. Reset clears every valid bit and empties the queue; the data
// registers are not reset.
module circumcircle_from_three_points_top #(
  parameter int COORD_BITS = 16,
  parameter int FRAC_BITS  = 16
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          in_valid,
  output logic                          in_ready,
  input  logic signed [COORD_BITS-1:0]  a_x,
  input  logic signed [COORD_BITS-1:0]  a_y,
  input  logic signed [COORD_BITS-1:0]  b_x,
  input  logic signed [COORD_BITS-1:0]  b_y,
  input  logic signed [COORD_BITS-1:0]  c_x,
  input  logic signed [COORD_BITS-1:0]  c_y,
  output logic                          out_valid,
  input  logic                          out_ready,
  output logic signed [ccf_pkg::OUT_BITS-1:0] center_x,
  output logic signed [ccf_pkg::OUT_BITS-1:0] center_y,
  output logic [ccf_pkg::OUT_BITS-1:0]        radius,
  output logic                          collinear,
  output logic                          saturated
);
  import ccf_pkg::*;

  localparam int CB   = COORD_BITS;
  localparam int FB   = FRAC_BITS;
  localparam int OW   = OUT_BITS;
  localparam int DW   = CB + 1;
  localparam int SW   = 2 * DW + 1;
  localparam int EW   = 2 * CB + 4;
  localparam int NW   = 3 * CB + 4;
  localparam int MW   = NW - 1;
  localparam int DNW  = MW + FB;
  localparam int DVW  = 2 * CB + 3;
  localparam int CW   = ((DNW > OW) ? DNW : OW) + 1;
  localparam int DXW  = ((OW > CB + FB) ? OW : CB + FB) + 1;
  localparam int LW   = (DXW + 1) / 2;
  localparam int HW   = DXW - LW;
  localparam int RW   = DXW + 1;
  localparam int DSB  = 2 * CB + 3;
  localparam int RSB  = 2 * OW + 2;
  localparam logic [CW-1:0] POS_LIM = (CW'(1) << (OW - 1)) - CW'(1);
  localparam logic [CW-1:0] NEG_LIM = CW'(1) << (OW - 1);
  localparam logic [RW-1:0] RAD_MAX = {{(RW - OW){1'b0}}, {OW{1'b1}}};

  logic en;

  // Stage 1: coordinates of b and c relative to a.
  logic                 v1;
  logic signed [CB-1:0] ax1, ay1;
  logic signed [DW-1:0] bx1, by1, cx1, cy1;

  always_ff @(posedge clk) begin
    if (rst) v1 <= 1'b0;
    else if (en) v1 <= in_valid;
  end

  always_ff @(posedge clk) begin
    if (en) begin
      ax1 <= a_x;
      ay1 <= a_y;
      bx1 <= DW'(b_x) - DW'(a_x);
      by1 <= DW'(b_y) - DW'(a_y);
      cx1 <= DW'(c_x) - DW'(a_x);
      cy1 <= DW'(c_y) - DW'(a_y);
    end
  end

  // Stage 2: squares and cross products.
  logic                   v2;
  logic signed [CB-1:0]   ax2, ay2;
  logic signed [DW-1:0]   bx2, by2, cx2, cy2;
  logic signed [2*DW-1:0] pbb, pyb, pcc, pyc, pbcy, pbycx;

  always_ff @(posedge clk) begin
    if (rst) v2 <= 1'b0;
    else if (en) v2 <= v1;
  end

  always_ff @(posedge clk) begin
    if (en) begin
      ax2   <= ax1;
      ay2   <= ay1;
      bx2   <= bx1;
      by2   <= by1;
      cx2   <= cx1;
      cy2   <= cy1;
      pbb   <= bx1 * bx1;
      pyb   <= by1 * by1;
      pcc   <= cx1 * cx1;
      pyc   <= cy1 * cy1;
      pbcy  <= bx1 * cy1;
      pbycx <= by1 * cx1;
    end
  end

  // Stage 3: squared lengths and twice the orientation determinant.
  logic                 v3;
  logic signed [CB-1:0] ax3, ay3;
  logic signed [DW-1:0] bx3, by3, cx3, cy3;
  logic signed [SW-1:0] sb3, sc3;
  logic signed [EW-1:0] den3;

  always_ff @(posedge clk) begin
    if (rst) v3 <= 1'b0;
    else if (en) v3 <= v2;
  end

  always_ff @(posedge clk) begin
    if (en) begin
      ax3  <= ax2;
      ay3  <= ay2;
      bx3  <= bx2;
      by3  <= by2;
      cx3  <= cx2;
      cy3  <= cy2;
      sb3  <= SW'(pbb) + SW'(pyb);
      sc3  <= SW'(pcc) + SW'(pyc);
      den3 <= (EW'(pbcy) - EW'(pbycx)) <<< 1;
    end
  end

  // Stage 4: numerator terms.
  logic                      v4;
  logic signed [CB-1:0]      ax4, ay4;
  logic signed [EW-1:0]      den4;
  logic signed [CB+EW-1:0]   m_axd, m_ayd;
  logic signed [DW+SW-1:0]   m_cysb, m_bysc, m_bxsc, m_cxsb;

  always_ff @(posedge clk) begin
    if (rst) v4 <= 1'b0;
    else if (en) v4 <= v3;
  end

  always_ff @(posedge clk) begin
    if (en) begin
      ax4    <= ax3;
      ay4    <= ay3;
      den4   <= den3;
      m_axd  <= ax3 * den3;
      m_ayd  <= ay3 * den3;
      m_cysb <= cy3 * sb3;
      m_bysc <= by3 * sc3;
      m_bxsc <= bx3 * sc3;
      m_cxsb <= cx3 * sb3;
    end
  end

  // Stage 5: signed numerators become magnitudes scaled by the fraction bits.
  logic signed [NW-1:0] nx5, ny5, mx5, my5;
  logic signed [EW-1:0] dabs5;
  logic                 negx5, negy5;

  always_comb begin
    nx5   = NW'(m_axd) + NW'(m_cysb) - NW'(m_bysc);
    ny5   = NW'(m_ayd) + NW'(m_bxsc) - NW'(m_cxsb);
    mx5   = nx5[NW-1] ? -nx5 : nx5;
    my5   = ny5[NW-1] ? -ny5 : ny5;
    dabs5 = den4[EW-1] ? -den4 : den4;
    negx5 = nx5[NW-1] ^ den4[EW-1];
    negy5 = ny5[NW-1] ^ den4[EW-1];
  end

  logic           dv  [0:DNW];
  logic [DNW-1:0] dnx [0:DNW];
  logic [DNW-1:0] dny [0:DNW];
  logic [DVW-1:0] drx [0:DNW];
  logic [DVW-1:0] dry [0:DNW];
  logic [DVW-1:0] dd  [0:DNW];
  logic [DSB-1:0] dsb [0:DNW];

  always_ff @(posedge clk) begin
    if (rst) dv[0] <= 1'b0;
    else if (en) dv[0] <= v4;
  end

  always_ff @(posedge clk) begin
    if (en) begin
      dnx[0] <= DNW'(mx5[MW-1:0]) << FB;
      dny[0] <= DNW'(my5[MW-1:0]) << FB;
      drx[0] <= '0;
      dry[0] <= '0;
      dd[0]  <= dabs5[DVW-1:0];
      dsb[0] <= {ax4, ay4, negx5, negy5, (den4 == '0)};
    end
  end

  for (genvar k = 0; k < DNW; k++) begin : g_div
    ccf_div_cell #(.NUM_W(DNW), .DIV_W(DVW), .SB_W(DSB)) u_cell (
      .clk        (clk),
      .rst        (rst),
      .en         (en),
      .valid_in   (dv[k]),
      .num_x_in   (dnx[k]),
      .rem_x_in   (drx[k]),
      .num_y_in   (dny[k]),
      .rem_y_in   (dry[k]),
      .divisor_in (dd[k]),
      .side_in    (dsb[k]),
      .valid_out  (dv[k+1]),
      .num_x_out  (dnx[k+1]),
      .rem_x_out  (drx[k+1]),
      .num_y_out  (dny[k+1]),
      .rem_y_out  (dry[k+1]),
      .divisor_out(dd[k+1]),
      .side_out   (dsb[k+1])
    );
  end

  // Stage 6: clip the quotients and restore their signs.
  logic signed [CB-1:0] axq, ayq;
  logic                 negxq, negyq, colq;
  logic [CW-1:0]        qx, qy, limx, limy, magx, magy;
  logic                 satx, saty;

  always_comb begin
    {axq, ayq, negxq, negyq, colq} = dsb[DNW];
    qx   = CW'(dnx[DNW]);
    qy   = CW'(dny[DNW]);
    limx = negxq ? NEG_LIM : POS_LIM;
    limy = negyq ? NEG_LIM : POS_LIM;
    satx = qx > limx;
    saty = qy > limy;
    magx = satx ? limx : qx;
    magy = saty ? limy : qy;
  end

  logic                 v6, sat6, col6;
  logic signed [OW-1:0] x6, y6;
  logic signed [CB-1:0] ax6, ay6;

  always_ff @(posedge clk) begin
    if (rst) v6 <= 1'b0;
    else if (en) v6 <= dv[DNW];
  end

  always_ff @(posedge clk) begin
    if (en) begin
      x6   <= negxq ? -OW'(magx) : OW'(magx);
      y6   <= negyq ? -OW'(magy) : OW'(magy);
      sat6 <= satx | saty;
      col6 <= colq;
      ax6  <= axq;
      ay6  <= ayq;
    end
  end

  // Stages 7 to 10: offsets from a, their magnitudes, split squares, and the sum.
  logic                  v7, v8, v9;
  logic [RSB-1:0]        side7, side8, side9;
  logic signed [DXW-1:0] dx7, dy7;
  logic [DXW-1:0]        ux8, uy8;
  logic [2*HW-1:0]       hhx, hhy;
  logic [HW+LW-1:0]      hlx, hly;
  logic [2*LW-1:0]       llx, lly;

  always_ff @(posedge clk) begin
    if (rst) begin
      v7 <= 1'b0;
      v8 <= 1'b0;
      v9 <= 1'b0;
    end else if (en) begin
      v7 <= v6;
      v8 <= v7;
      v9 <= v8;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      side7 <= {x6, y6, sat6, col6};
      dx7   <= DXW'(x6) - (DXW'(ax6) <<< FB);
      dy7   <= DXW'(y6) - (DXW'(ay6) <<< FB);
      side8 <= side7;
      ux8   <= dx7[DXW-1] ? DXW'(-dx7) : DXW'(dx7);
      uy8   <= dy7[DXW-1] ? DXW'(-dy7) : DXW'(dy7);
      side9 <= side8;
      hhx   <= ux8[DXW-1:LW] * ux8[DXW-1:LW];
      hlx   <= ux8[DXW-1:LW] * ux8[LW-1:0];
      llx   <= ux8[LW-1:0] * ux8[LW-1:0];
      hhy   <= uy8[DXW-1:LW] * uy8[DXW-1:LW];
      hly   <= uy8[DXW-1:LW] * uy8[LW-1:0];
      lly   <= uy8[LW-1:0] * uy8[LW-1:0];
    end
  end

  logic              sv  [0:RW];
  logic [2*RW-1:0]   srad[0:RW];
  logic [RW+1:0]     srem[0:RW];
  logic [RW-1:0]     sroot[0:RW];
  logic [RSB-1:0]    ssb [0:RW];

  always_ff @(posedge clk) begin
    if (rst) sv[0] <= 1'b0;
    else if (en) sv[0] <= v9;
  end

  always_ff @(posedge clk) begin
    if (en) begin
      srad[0]  <= ((2*RW)'(hhx) << (2*LW)) + ((2*RW)'(hlx) << (LW + 1)) + (2*RW)'(llx)
                + ((2*RW)'(hhy) << (2*LW)) + ((2*RW)'(hly) << (LW + 1)) + (2*RW)'(lly);
      srem[0]  <= '0;
      sroot[0] <= '0;
      ssb[0]   <= side9;
    end
  end

  for (genvar k = 0; k < RW; k++) begin : g_sqrt
    ccf_sqrt_cell #(.ROOT_W(RW), .SB_W(RSB)) u_cell (
      .clk      (clk),
      .rst      (rst),
      .en       (en),
      .valid_in (sv[k]),
      .rad_in   (srad[k]),
      .rem_in   (srem[k]),
      .root_in  (sroot[k]),
      .side_in  (ssb[k]),
      .valid_out(sv[k+1]),
      .rad_out  (srad[k+1]),
      .rem_out  (srem[k+1]),
      .root_out (sroot[k+1]),
      .side_out (ssb[k+1])
    );
  end

  // Result formatting; a collinear triangle overrides every other field.
  ccf_result_t          res;
  logic signed [OW-1:0] rx, ry;
  logic                 rsat, rcol, satr;

  always_comb begin
    {rx, ry, rsat, rcol} = ssb[RW];
    satr = sroot[RW] > RAD_MAX;
    if (rcol) begin
      res = '0;
      res.collinear = 1'b1;
    end else begin
      res.center_x  = rx;
      res.center_y  = ry;
      res.radius    = satr ? OW'(RAD_MAX) : sroot[RW][OW-1:0];
      res.collinear = 1'b0;
      res.saturated = rsat | satr;
    end
  end

  // Two-entry output queue.
  ccf_result_t q_mem [0:1];
  logic        wr_ptr, rd_ptr;
  logic [1:0]  count;
  logic        push, pop;

  assign en       = !(sv[RW] && (count == 2'd2));
  assign in_ready = en;
  assign push     = en && sv[RW];
  assign pop      = out_valid && out_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= 1'b0;
      rd_ptr <= 1'b0;
      count  <= 2'd0;
    end else begin
      if (push) wr_ptr <= !wr_ptr;
      if (pop) rd_ptr <= !rd_ptr;
      count <= count + {1'b0, push} - {1'b0, pop};
    end
  end

  always_ff @(posedge clk) begin
    if (push) q_mem[wr_ptr] <= res;
  end

  assign out_valid = count != 2'd0;
  assign center_x  = q_mem[rd_ptr].center_x;
  assign center_y  = q_mem[rd_ptr].center_y;
  assign radius    = q_mem[rd_ptr].radius;
  assign collinear = q_mem[rd_ptr].collinear;
  assign saturated = q_mem[rd_ptr].saturated;

`ifndef SYNTHESIS
  a_count_bound: assert property (@(posedge clk) disable iff (rst) count <= 2'd2)
    else $error("output queue overfilled");

  a_collinear_zero: assert property (@(posedge clk) disable iff (rst)
    out_valid && collinear |-> center_x == '0 && center_y == '0 && radius == '0 && !saturated)
    else $error("collinear result carries nonzero fields");

  a_stall_holds: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(radius) && $stable(center_x))
    else $error("stalled result changed");

  a_full_blocks: assert property (@(posedge clk) disable iff (rst)
    count == 2'd2 && !out_ready |=> count == 2'd2)
    else $error("full queue lost an entry");
`endif

endmodule
